FILE: hw/rtl/gzmd_pkg.sv
// ----------------------------------------------------------------------------
// gzmd_pkg
// constants and types shared by the gzip member deframer
// ----------------------------------------------------------------------------
package gzmd_pkg;

  localparam logic [7:0] MAGIC_A        = 8'h1F;
  localparam logic [7:0] MAGIC_B        = 8'h8B;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;
  localparam logic [4:0] MIN_MEMBER     = 5'd20;
  localparam logic [3:0] TAIL_LEN       = 4'd8;

  // result queue depth, room for three results beyond the one on the port
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 136;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_METH  = 3'd3,
    ST_TRUNC     = 3'd4
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  header_flags;
    logic [31:0] mod_time;
    logic [7:0]  extra_flags;
    logic [7:0]  os_code;
    logic [31:0] stored_crc;
    logic [31:0] stored_size;
    logic        end_mark;
  } result_t;

endpackage

FILE: hw/rtl/gzip_member_deframer_core.sv
// ----------------------------------------------------------------------------
// gzip_member_deframer_core
// splits a gzip member into header fields, deflate payload and trailer
// ----------------------------------------------------------------------------
// The in_ channel carries one byte of a gzip member per request, in_tlast
// marking its last byte. The out_ channel gives payload bytes (out_tuser 0)
// and, after the last byte, one summary record (out_tuser 1, out_tlast 1)
// with status, header fields and the stored CRC-32 and size.
// Each byte is decoded in the cycle it is accepted and its results are
// written into a four-entry result queue that drives out_. Payload bytes
// are held back by an eight-byte delay line, so a body byte leaves once
// eight more body bytes have arrived, and the trailer never leaves as
// payload. Throughput is one byte per cycle while in_tready is high. The
// last byte of a member with any payload yields two results, and the
// single out_ port drains them at one per cycle while out_tready is high.
// in_tready falls while fewer than two queue entries are free. A stalled
// receiver therefore stops input once three results are waiting.
// Reset (synchronous, rst_n low) empties the queue and sends the parser to
// the first magic byte; a member's last byte resets the parser alone.
// ----------------------------------------------------------------------------
module gzip_member_deframer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gzmd_pkg::IN_TDATA_W-1:0]     in_tdata,  // data_byte[7:0]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // payload_byte[7:0] status[10:8] header_flags[18:11] mod_time[50:19]
  // extra_flags[58:51] os_code[66:59] stored_crc[98:67] stored_size[130:99]
  output logic [gzmd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser, // kind
  output logic                                out_tlast
);

  typedef enum logic [3:0] {
    PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLG, PH_MTIME, PH_XFL, PH_OS,
    PH_XLEN, PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC, PH_BODY, PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  total_r, total_nxt;
  logic [16:0] fc_r, fc_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] mtime_r, mtime_nxt;
  logic [7:0]  xfl_r, xfl_nxt;
  logic [7:0]  os_r, os_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  tail_r [8];
  logic [7:0]  tail_nxt [8];

  logic [gzmd_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic [gzmd_pkg::QAW-1:0] wp_r, rp_r, wp2;
  gzmd_pkg::result_t        q_r [gzmd_pkg::QDEPTH];
  gzmd_pkg::result_t        pay_res, sum_res, head;

  logic       in_acc, out_acc, emit_pay, fin;
  logic [7:0] b;
  logic [2:0] st;
  logic [1:0] n_push;

  // first optional header part at or after the given one that FLG asks for
  function automatic phase_t next_part(input phase_t from, input logic [7:0] flg);
    phase_t res;
    res = PH_BODY;
    if (from <= PH_HCRC && flg[1]) res = PH_HCRC;
    if (from <= PH_COMMENT && flg[4]) res = PH_COMMENT;
    if (from <= PH_NAME && flg[3]) res = PH_NAME;
    if (from <= PH_XLEN && flg[2]) res = PH_XLEN;
    return res;
  endfunction

  assign in_tready = (cnt_r <= (gzmd_pkg::QAW+1)'(gzmd_pkg::QDEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;
  assign b         = in_tdata[7:0];
  assign fin       = in_tlast;
  assign emit_pay  = (phase_r == PH_BODY) && (fill_r >= gzmd_pkg::TAIL_LEN);

  always_comb begin
    phase_nxt = phase_r;
    total_nxt = (total_r < gzmd_pkg::MIN_MEMBER) ? total_r + 5'd1 : total_r;
    fc_nxt    = fc_r;
    flags_nxt = flags_r;
    mtime_nxt = mtime_r;
    xfl_nxt   = xfl_r;
    os_nxt    = os_r;
    fill_nxt  = fill_r;
    err_nxt   = err_r;
    tail_nxt  = tail_r;
    case (phase_r)
      PH_MAGIC1: begin
        if (b == gzmd_pkg::MAGIC_A) phase_nxt = PH_MAGIC2;
        else begin
          err_nxt   = gzmd_pkg::ST_BAD_MAGIC;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_MAGIC2: begin
        if (b == gzmd_pkg::MAGIC_B) phase_nxt = PH_METHOD;
        else begin
          err_nxt   = gzmd_pkg::ST_BAD_MAGIC;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_METHOD: begin
        if (b == gzmd_pkg::METHOD_DEFLATE) phase_nxt = PH_FLG;
        else begin
          err_nxt   = gzmd_pkg::ST_BAD_METH;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_FLG: begin
        flags_nxt = b;
        fc_nxt    = '0;
        phase_nxt = PH_MTIME;
      end
      PH_MTIME: begin
        mtime_nxt = mtime_r | ({24'd0, b} << {fc_r[1:0], 3'b000});
        fc_nxt    = fc_r + 17'd1;
        if (fc_r[1:0] == 2'd3) begin
          fc_nxt    = '0;
          phase_nxt = PH_XFL;
        end
      end
      PH_XFL: begin
        xfl_nxt   = b;
        phase_nxt = PH_OS;
      end
      PH_OS: begin
        os_nxt    = b;
        fc_nxt    = '0;
        phase_nxt = next_part(PH_XLEN, flags_r);
      end
      PH_XLEN: begin
        // bit 16 marks that the low length byte was taken
        if (fc_r == '0) fc_nxt = {1'b1, 8'd0, b};
        else begin
          fc_nxt = {1'b0, b, fc_r[7:0]};
          if ({b, fc_r[7:0]} == 16'd0) phase_nxt = next_part(PH_NAME, flags_r);
          else phase_nxt = PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        fc_nxt = {1'b0, fc_r[15:0] - 16'd1};
        if (fc_r[15:0] == 16'd1) phase_nxt = next_part(PH_NAME, flags_r);
      end
      PH_NAME: begin
        if (b == 8'd0) phase_nxt = next_part(PH_COMMENT, flags_r);
      end
      PH_COMMENT: begin
        if (b == 8'd0) begin
          fc_nxt    = '0;
          phase_nxt = next_part(PH_HCRC, flags_r);
        end
      end
      PH_HCRC: begin
        fc_nxt = fc_r + 17'd1;
        if (fc_r != '0) begin
          fc_nxt    = '0;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (emit_pay) begin
          for (int i = 0; i < 7; i++) tail_nxt[i] = tail_r[i+1];
          tail_nxt[7] = b;
        end else begin
          tail_nxt[fill_r[2:0]] = b;
          fill_nxt = fill_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // summary status from the state after this byte
  always_comb begin
    if (total_nxt < gzmd_pkg::MIN_MEMBER) st = gzmd_pkg::ST_TOO_SHORT;
    else if (err_nxt != gzmd_pkg::ST_OK) st = err_nxt;
    else if (phase_nxt != PH_BODY || fill_nxt < gzmd_pkg::TAIL_LEN) st = gzmd_pkg::ST_TRUNC;
    else st = gzmd_pkg::ST_OK;
  end

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = tail_r[0];
    sum_res              = '0;
    sum_res.kind         = 1'b1;
    sum_res.status       = st;
    sum_res.header_flags = flags_nxt;
    sum_res.mod_time     = mtime_nxt;
    sum_res.extra_flags  = xfl_nxt;
    sum_res.os_code      = os_nxt;
    if (st == gzmd_pkg::ST_OK) begin
      sum_res.stored_crc  = {tail_nxt[3], tail_nxt[2], tail_nxt[1], tail_nxt[0]};
      sum_res.stored_size = {tail_nxt[7], tail_nxt[6], tail_nxt[5], tail_nxt[4]};
    end
    sum_res.end_mark = 1'b1;
  end

  assign n_push  = in_acc ? ({1'b0, emit_pay} + {1'b0, fin}) : 2'd0;
  assign wp2     = emit_pay ? wp_r + 1'b1 : wp_r;
  assign cnt_nxt = cnt_r + (gzmd_pkg::QAW+1)'(n_push) - (gzmd_pkg::QAW+1)'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC1;
      total_r <= '0;
      fc_r    <= '0;
      flags_r <= '0;
      mtime_r <= '0;
      xfl_r   <= '0;
      os_r    <= '0;
      fill_r  <= '0;
      err_r   <= gzmd_pkg::ST_OK;
      cnt_r   <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_r + (gzmd_pkg::QAW)'(n_push);
      if (out_acc) rp_r <= rp_r + 1'b1;
      if (in_acc) begin
        if (fin) begin
          // next member starts from scratch
          phase_r <= PH_MAGIC1;
          total_r <= '0;
          fc_r    <= '0;
          flags_r <= '0;
          mtime_r <= '0;
          xfl_r   <= '0;
          os_r    <= '0;
          fill_r  <= '0;
          err_r   <= gzmd_pkg::ST_OK;
        end else begin
          phase_r <= phase_nxt;
          total_r <= total_nxt;
          fc_r    <= fc_nxt;
          flags_r <= flags_nxt;
          mtime_r <= mtime_nxt;
          xfl_r   <= xfl_nxt;
          os_r    <= os_nxt;
          fill_r  <= fill_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

  // delay line and result queue, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tail_r <= tail_nxt;
      if (emit_pay) q_r[wp_r] <= pay_res;
      if (fin) q_r[wp2] <= sum_res;
    end
  end

  assign head       = q_r[rp_r];
  assign out_tuser  = head.kind;
  assign out_tlast  = head.end_mark;
  assign out_tdata  = {5'd0, head.stored_size, head.stored_crc, head.os_code,
                       head.extra_flags, head.mod_time, head.header_flags,
                       head.status, head.payload_byte};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (gzmd_pkg::QAW+1)'(gzmd_pkg::QDEPTH))
    else $error("result queue overflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= gzmd_pkg::TAIL_LEN)
    else $error("delay line fill out of range");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= gzmd_pkg::MIN_MEMBER)
    else $error("byte count past saturation");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fin |=> out_tvalid && phase_r == PH_MAGIC1 && fill_r == '0)
    else $error("final byte left no summary or state not cleared");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("summary record without end mark");

  a_pay_only_body: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit_pay |-> fill_r == gzmd_pkg::TAIL_LEN && err_r == gzmd_pkg::ST_OK)
    else $error("payload emitted outside a clean body");

endmodule

FILE: tb/tb_gzip_member_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gzip_member_deframer_core
// self-checking bench for the gzip member deframer
// ----------------------------------------------------------------------------
// Builds gzip members byte by byte (directed headers, malformed members and
// random members with noise and broken ones mixed in). A behavioral parser in
// the bench predicts every payload byte and summary record. Results are
// checked in order, field by field, under random idling on both channels and
// a long output stall.
// ----------------------------------------------------------------------------
module tb_gzip_member_deframer_core;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 400;

  typedef enum logic [3:0] {
    P_MAGIC1, P_MAGIC2, P_METHOD, P_FLG, P_MTIME, P_XFL, P_OS,
    P_XLEN, P_EXTRA, P_NAME, P_COMMENT, P_HCRC, P_BODY, P_DRAIN
  } parse_phase_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [gzmd_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tlast   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [gzmd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tlast;

  always #5 clk = ~clk;

  gzip_member_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // header parser mirror
  parse_phase_t      hp_phase;
  logic [4:0]        hp_total;
  logic [16:0]       hp_fld;
  logic [7:0]        hp_flg;
  logic [31:0]       hp_mtime;
  logic [7:0]        hp_xfl;
  logic [7:0]        hp_os;
  logic [7:0]        hp_tail [8];
  logic [3:0]        hp_fill;
  gzmd_pkg::status_t hp_err;

  gzmd_pkg::result_t expected_q [$];
  logic [7:0]        member_buf [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;
  int hold_seen_cnt = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int members_sent  = 0;
  int payloads_seen = 0;
  int records_seen  = 0;
  int ok_seen       = 0;
  int error_seen    = 0;
  int mismatches    = 0;

  function automatic void clear_parser();
    hp_phase = P_MAGIC1;
    hp_total = '0;
    hp_fld   = '0;
    hp_flg   = '0;
    hp_mtime = '0;
    hp_xfl   = '0;
    hp_os    = '0;
    for (int k = 0; k < 8; k++) hp_tail[k] = '0;
    hp_fill  = '0;
    hp_err   = gzmd_pkg::ST_OK;
  endfunction

  // first optional header section at or after 'from' that FLG asks for
  function automatic parse_phase_t next_section(parse_phase_t from);
    if (from <= P_XLEN && hp_flg[2]) return P_XLEN;
    if (from <= P_NAME && hp_flg[3]) return P_NAME;
    if (from <= P_COMMENT && hp_flg[4]) return P_COMMENT;
    if (from <= P_HCRC && hp_flg[1]) return P_HCRC;
    return P_BODY;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fin);
    gzmd_pkg::result_t r;
    gzmd_pkg::status_t st;
    if (hp_total < gzmd_pkg::MIN_MEMBER) hp_total++;
    case (hp_phase)
      P_MAGIC1: begin
        if (b == gzmd_pkg::MAGIC_A) hp_phase = P_MAGIC2;
        else begin
          hp_err = gzmd_pkg::ST_BAD_MAGIC;
          hp_phase = P_DRAIN;
        end
      end
      P_MAGIC2: begin
        if (b == gzmd_pkg::MAGIC_B) hp_phase = P_METHOD;
        else begin
          hp_err = gzmd_pkg::ST_BAD_MAGIC;
          hp_phase = P_DRAIN;
        end
      end
      P_METHOD: begin
        if (b == gzmd_pkg::METHOD_DEFLATE) hp_phase = P_FLG;
        else begin
          hp_err = gzmd_pkg::ST_BAD_METH;
          hp_phase = P_DRAIN;
        end
      end
      P_FLG: begin
        hp_flg = b;
        hp_fld = '0;
        hp_phase = P_MTIME;
      end
      P_MTIME: begin
        hp_mtime = hp_mtime | (32'(b) << (8 * hp_fld[1:0]));
        hp_fld++;
        if (hp_fld >= 4) begin
          hp_fld = '0;
          hp_phase = P_XFL;
        end
      end
      P_XFL: begin
        hp_xfl = b;
        hp_phase = P_OS;
      end
      P_OS: begin
        hp_os = b;
        hp_fld = '0;
        hp_phase = next_section(P_XLEN);
      end
      P_XLEN: begin
        // bit 16 marks that the low length byte is in
        if (hp_fld == 0) hp_fld = {1'b1, 8'h00, b};
        else begin
          hp_fld = {1'b0, b, hp_fld[7:0]};
          hp_phase = (hp_fld == 0) ? next_section(P_NAME) : P_EXTRA;
        end
      end
      P_EXTRA: begin
        hp_fld = {1'b0, hp_fld[15:0] - 16'd1};
        if (hp_fld == 0) hp_phase = next_section(P_NAME);
      end
      P_NAME: begin
        if (b == 8'h00) hp_phase = next_section(P_COMMENT);
      end
      P_COMMENT: begin
        if (b == 8'h00) begin
          hp_fld = '0;
          hp_phase = next_section(P_HCRC);
        end
      end
      P_HCRC: begin
        hp_fld++;
        if (hp_fld >= 2) begin
          hp_fld = '0;
          hp_phase = P_BODY;
        end
      end
      P_BODY: begin
        if (hp_fill >= gzmd_pkg::TAIL_LEN) begin
          r = '0;
          r.payload_byte = hp_tail[0];
          expected_q.push_back(r);
          for (int k = 0; k < 7; k++) hp_tail[k] = hp_tail[k + 1];
          hp_tail[7] = b;
        end else begin
          hp_tail[hp_fill[2:0]] = b;
          hp_fill++;
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (hp_total < gzmd_pkg::MIN_MEMBER) st = gzmd_pkg::ST_TOO_SHORT;
      else if (hp_err != gzmd_pkg::ST_OK) st = hp_err;
      else if (hp_phase != P_BODY || hp_fill < gzmd_pkg::TAIL_LEN) st = gzmd_pkg::ST_TRUNC;
      else st = gzmd_pkg::ST_OK;
      r = '0;
      r.kind         = 1'b1;
      r.status       = st;
      r.header_flags = hp_flg;
      r.mod_time     = hp_mtime;
      r.extra_flags  = hp_xfl;
      r.os_code      = hp_os;
      if (st == gzmd_pkg::ST_OK) begin
        r.stored_crc  = {hp_tail[3], hp_tail[2], hp_tail[1], hp_tail[0]};
        r.stored_size = {hp_tail[7], hp_tail[6], hp_tail[5], hp_tail[4]};
      end
      r.end_mark = 1'b1;
      expected_q.push_back(r);
      clear_parser();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    parse_byte(b, fin);
  endtask

  task automatic send_member();
    int n;
    n = member_buf.size();
    for (int i = 0; i < n; i++) send_byte(member_buf[i], i == n - 1);
    if (n > 0) members_sent++;
    member_buf.delete();
  endtask

  // sender pause: drop the request and let every expected result come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic build_member(input logic [7:0] flg, input logic [31:0] mtime,
                              input logic [7:0] xfl, input logic [7:0] os,
                              input int xlen, input int name_len,
                              input int cmt_len, input int body_len);
    member_buf.push_back(gzmd_pkg::MAGIC_A);
    member_buf.push_back(gzmd_pkg::MAGIC_B);
    member_buf.push_back(gzmd_pkg::METHOD_DEFLATE);
    member_buf.push_back(flg);
    for (int k = 0; k < 4; k++) member_buf.push_back(mtime[8*k +: 8]);
    member_buf.push_back(xfl);
    member_buf.push_back(os);
    if (flg[2]) begin
      member_buf.push_back(8'(xlen));
      member_buf.push_back(8'(xlen >> 8));
      for (int k = 0; k < xlen; k++) member_buf.push_back(8'($urandom));
    end
    if (flg[3]) begin
      for (int k = 0; k < name_len; k++) member_buf.push_back(8'($urandom_range(1, 255)));
      member_buf.push_back(8'h00);
    end
    if (flg[4]) begin
      for (int k = 0; k < cmt_len; k++) member_buf.push_back(8'($urandom_range(1, 255)));
      member_buf.push_back(8'h00);
    end
    if (flg[1]) begin
      member_buf.push_back(8'($urandom));
      member_buf.push_back(8'($urandom));
    end
    // body, then crc32 and isize
    for (int k = 0; k < body_len + 8; k++) member_buf.push_back(8'($urandom));
  endtask

  task automatic cut_member(input int keep);
    while (member_buf.size() > keep) void'(member_buf.pop_back());
  endtask

  task automatic test_well_formed_members();
    // shortest legal member: bare header, two body bytes, trailer
    build_member(8'h00, 32'h0000_0000, 8'h00, 8'h00, 0, 0, 0, 2);
    send_member();
    // empty payload, name brings it to the minimum length
    build_member(8'h08, 32'h1234_5678, 8'h02, 8'h03, 0, 1, 0, 0);
    send_member();
    build_member(8'h1E, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 3, 4, 2, 4);
    send_member();
    // extra field of zero length
    build_member(8'h04, 32'($urandom), 8'h04, 8'h0B, 0, 0, 0, 5);
    send_member();
    // reserved flag bits and the text bit
    build_member(8'hE1, 32'($urandom), 8'h00, 8'hFF, 0, 0, 0, 2);
    send_member();
    // extra length with a zero low byte, member ends inside the extra field
    build_member(8'h06, 32'($urandom), 8'h02, 8'h00, 256, 0, 0, 3);
    cut_member(30);
    send_member();
    build_member(8'h12, 32'($urandom), 8'h80, 8'h7F, 0, 0, 6, 2);
    send_member();
  endtask

  task automatic test_malformed_members();
    build_member(8'h00, 32'($urandom), 8'h00, 8'h03, 0, 0, 0, 6);
    member_buf[0] = 8'h00;
    send_member();
    build_member(8'h00, 32'($urandom), 8'h00, 8'h03, 0, 0, 0, 6);
    member_buf[1] = 8'h8C;
    send_member();
    // bad method, later bytes look like a new magic and must be drained
    build_member(8'h00, 32'($urandom), 8'h00, 8'h03, 0, 0, 0, 8);
    member_buf[2] = 8'h07;
    member_buf[12] = gzmd_pkg::MAGIC_A;
    member_buf[13] = gzmd_pkg::MAGIC_B;
    send_member();
    // short and bad magic at once: too short wins
    member_buf.push_back(8'hFF);
    repeat (4) member_buf.push_back(8'($urandom));
    send_member();
    member_buf.push_back(gzmd_pkg::MAGIC_A);
    send_member();
    // 19 bytes: one payload byte leaves before the member proves too short
    build_member(8'h00, 32'($urandom), 8'h00, 8'h03, 0, 0, 0, 1);
    send_member();
    // name never terminated
    build_member(8'h08, 32'($urandom), 8'h00, 8'h03, 0, 20, 0, 4);
    cut_member(25);
    send_member();
    // trailer cut to five bytes
    build_member(8'h08, 32'($urandom), 8'h00, 8'h03, 0, 15, 0, 0);
    cut_member(31);
    send_member();
  endtask

  task automatic test_random_members(input int byte_budget);
    int start;
    int pick;
    int body;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      pick = $urandom_range(19);
      body = (pick == 0) ? $urandom_range(60, 120) : $urandom_range(0, 16);
      build_member(8'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
                   ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(4),
                   $urandom_range(5), $urandom_range(5), body);
      if (pick == 17) begin
        member_buf[$urandom_range(2)] = 8'($urandom);
      end else if (pick == 18) begin
        cut_member($urandom_range(1, member_buf.size() - 1));
      end else if (pick == 19) begin
        // noise, sometimes opening like a real member
        member_buf.delete();
        if ($urandom_range(1)) member_buf.push_back(gzmd_pkg::MAGIC_A);
        repeat ($urandom_range(1, 25)) member_buf.push_back(8'($urandom));
      end
      send_member();
    end
  endtask

  task automatic test_output_backpressure();
    hold_req_cnt++;
    build_member(8'h0A, 32'($urandom), 8'($urandom), 8'($urandom), 2, 3, 0, 24);
    send_member();
    wait_drained();
  endtask

  // receiver: random ready, long hold-off on request
  always @(negedge clk) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    gzmd_pkg::result_t got;
    gzmd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind         = out_tuser;
      got.payload_byte = out_tdata[7:0];
      got.status       = out_tdata[10:8];
      got.header_flags = out_tdata[18:11];
      got.mod_time     = out_tdata[50:19];
      got.extra_flags  = out_tdata[58:51];
      got.os_code      = out_tdata[66:59];
      got.stored_crc   = out_tdata[98:67];
      got.stored_size  = out_tdata[130:99];
      got.end_mark     = out_tlast;
      if (got.kind) records_seen++;
      else payloads_seen++;
      if (got.kind && got.status == gzmd_pkg::ST_OK) ok_seen++;
      else if (got.kind) error_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: tuser %0b tdata %0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("status", want.status, got.status);
        check_field("header_flags", want.header_flags, got.header_flags);
        check_field("mod_time", want.mod_time, got.mod_time);
        check_field("extra_flags", want.extra_flags, got.extra_flags);
        check_field("os_code", want.os_code, got.os_code);
        check_field("stored_crc", want.stored_crc, got.stored_crc);
        check_field("stored_size", want.stored_size, got.stored_size);
        check_field("end_mark", want.end_mark, got.end_mark);
      end
    end
  end

  // watchdog: cycles in a row with no request accepted on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("gzip_member_deframer_core regression: fail");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 86;
    test_well_formed_members();
    test_malformed_members();

    send_idle_pct = 86;
    recv_idle_pct = 27;
    test_random_members(30);
    test_output_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_members(30);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d members (%0d bytes in): %0d payload bytes, %0d records out",
             members_sent, bytes_sent, payloads_seen, records_seen);
    $display("records: %0d ok, %0d with an error status; one long output stall",
             ok_seen, error_seen);
    if (mismatches == 0) begin
      $display("gzip_member_deframer_core regression: pass");
    end else begin
      $display("gzip_member_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: gzip_member_deframer_core.f
hw/rtl/gzmd_pkg.sv
hw/rtl/gzip_member_deframer_core.sv
tb/tb_gzip_member_deframer_core.sv
